[rtl/fbpa_pkg.sv]
// Shared types and constants of the fixed-size block pool allocator.
// Used by every module of the block but fbpa_ram; depends on nothing else.
package fbpa_pkg;

  // Field widths of the request, the result and the link entries.
  localparam int IDX_W      = 8;
  localparam int LINK_W     = 9;
  localparam int COUNT_W    = 9;
  localparam int OFFSET_W   = 24;
  localparam int BSIZE_W    = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;

  // The pool never holds more blocks than an 8-bit index can name.
  localparam int POOL_LIMIT = 256;

  // Register reset values.
  localparam logic [COUNT_W-1:0] NUM_BLOCKS_RST = 9'd256;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 17'd64;

  // Free count saturates at the top of its range.
  localparam logic [COUNT_W-1:0] FREE_MAX = 9'd511;

  // Request operation codes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

  // One request: allocate or free.
  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] free_index;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic                granted;
    logic [IDX_W-1:0]    block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_count;
  } out_res_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the request, write the link store, read the head's link
    logic commit;  // update pool state and load the result register
  } ctrl_cmd_t;

endpackage

[rtl/fixed_block_pool_allocator.sv]
// Fixed-size block pool allocator with a lazily linked free list.
// A request is accepted in the idle state and committed in the commit state,
// and its result strobe is registered from the commit. No new request is taken
// during the commit: an allocate needs the registered link read for the next head.
// Reset (synchronous, rst_n low) restores the register defaults and a full pool;
// the link store is not cleared, since links are set up as the pool is used.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fbpa_pkg::in_req_t               in_req,
  output logic                            out_strobe,
  output fbpa_pkg::out_res_t              out_res,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  fbpa_pkg::ctrl_cmd_t cmd;

  // Sequencing of each request.
  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // Pool state, link store and result.
  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_res   (out_res)
  );

endmodule

[rtl/fbpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fbpa_ctrl.sv]
// Controller of the block pool allocator: request handshake and sequencing.
// Depends on fbpa_pkg for the state type and the command struct.
module fbpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_strobe,
  output fbpa_pkg::ctrl_cmd_t cmd
);

  fbpa_pkg::fsm_state_t state_r, state_nxt;
  logic                 out_valid_r;

  // State register and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  // Next state and commands: accept in idle, commit in the cycle after.
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      fbpa_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = fbpa_pkg::ST_COMMIT;
        end
      end
      fbpa_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = fbpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != fbpa_pkg::ST_IDLE);
  assign out_strobe = out_valid_r;

endmodule

[rtl/fbpa_datapath.sv]
// Datapath of the block pool allocator: configuration, free-list state,
// link store and result register. Depends on fbpa_pkg and fbpa_ram.
module fbpa_datapath #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbpa_pkg::ctrl_cmd_t                 cmd,
  input  fbpa_pkg::in_req_t                   in_req,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output fbpa_pkg::out_res_t                  out_res
);

  localparam int DEPTH = (MAX_BLOCKS < fbpa_pkg::POOL_LIMIT) ? MAX_BLOCKS
                                                             : fbpa_pkg::POOL_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [fbpa_pkg::COUNT_W-1:0] DEPTH_N = fbpa_pkg::COUNT_W'(DEPTH);

  // Configuration registers.
  logic [fbpa_pkg::COUNT_W-1:0] num_blocks_r;
  logic [fbpa_pkg::BSIZE_W-1:0] block_size_r;

  // Free-list state.
  logic [fbpa_pkg::IDX_W-1:0]   head_r;
  logic                         head_valid_r;
  logic [fbpa_pkg::COUNT_W-1:0] free_r;
  logic [fbpa_pkg::COUNT_W-1:0] init_r;

  // Request held between accept and commit.
  logic                         op_mode_r;
  logic [fbpa_pkg::IDX_W-1:0]   op_fidx_r;
  logic                         fwd_r;
  logic [fbpa_pkg::LINK_W-1:0]  fwd_link_r;
  logic                         oob_r;

  fbpa_pkg::out_res_t           out_res_r;

  logic [fbpa_pkg::COUNT_W-1:0] pool_n;
  logic [fbpa_pkg::COUNT_W-1:0] cfg_pool_n;
  logic                         init_pending;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [fbpa_pkg::LINK_W-1:0]  ram_wdata;
  logic [fbpa_pkg::LINK_W-1:0]  ram_rdata;
  logic [fbpa_pkg::LINK_W-1:0]  head_link;
  logic [fbpa_pkg::IDX_W+fbpa_pkg::BSIZE_W-1:0] product;
  logic [fbpa_pkg::COUNT_W-1:0] free_dec;

  // Effective block count, limited by the store depth.
  assign pool_n     = (num_blocks_r > DEPTH_N) ? DEPTH_N : num_blocks_r;
  assign cfg_pool_n = (cfg_data[fbpa_pkg::COUNT_W-1:0] > DEPTH_N)
                      ? DEPTH_N : cfg_data[fbpa_pkg::COUNT_W-1:0];
  assign init_pending = (init_r < pool_n);

  // Link store writes happen at accept: the lazy link set-up for an
  // allocate, or the new head's link for a free.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_r[AW-1:0];
    ram_wdata = init_r + fbpa_pkg::LINK_W'(1);
    if (cmd.accept) begin
      if (in_req.mode == fbpa_pkg::MODE_ALLOC) begin
        ram_we = init_pending;
      end else begin
        ram_we    = ({1'b0, in_req.free_index} < DEPTH_N);
        ram_waddr = in_req.free_index[AW-1:0];
        ram_wdata = head_valid_r ? {1'b0, head_r} : pool_n;
      end
    end
  end

  fbpa_ram #(
    .WIDTH (fbpa_pkg::LINK_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // The head's link: the lazily written value when it was set in the same
  // request, zero for a head beyond the store, else the memory contents.
  assign head_link = fwd_r ? fwd_link_r : (oob_r ? '0 : ram_rdata);
  assign product   = {{fbpa_pkg::BSIZE_W{1'b0}}, head_r} *
                     {{fbpa_pkg::IDX_W{1'b0}}, block_size_r};
  assign free_dec  = free_r - fbpa_pkg::COUNT_W'(1);

  // Request capture at accept.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_mode_r  <= in_req.mode;
      op_fidx_r  <= in_req.free_index;
      fwd_r      <= init_pending && (init_r[fbpa_pkg::IDX_W-1:0] == head_r);
      fwd_link_r <= init_r + fbpa_pkg::LINK_W'(1);
      oob_r      <= ({1'b0, head_r} >= DEPTH_N);
    end
  end

  // Configuration, pool re-creation and state update at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r <= fbpa_pkg::NUM_BLOCKS_RST;
      block_size_r <= fbpa_pkg::BLOCK_SIZE_RST;
      head_r       <= '0;
      head_valid_r <= 1'b1;
      free_r       <= DEPTH_N;
      init_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::CFG_NUM_BLOCKS: begin
          num_blocks_r <= cfg_data[fbpa_pkg::COUNT_W-1:0];
          head_r       <= '0;
          head_valid_r <= 1'b1;
          free_r       <= cfg_pool_n;
          init_r       <= '0;
        end
        fbpa_pkg::CFG_BLOCK_SIZE: begin
          block_size_r <= cfg_data[fbpa_pkg::BSIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.commit) begin
      if (op_mode_r == fbpa_pkg::MODE_ALLOC) begin
        if (init_pending) begin
          init_r <= init_r + fbpa_pkg::COUNT_W'(1);
        end
        if (free_r != '0) begin
          free_r <= free_dec;
          if (free_dec != '0) begin
            head_r <= head_link[fbpa_pkg::IDX_W-1:0];
          end else begin
            head_valid_r <= 1'b0;
          end
        end
      end else begin
        head_r       <= op_fidx_r;
        head_valid_r <= 1'b1;
        if (free_r != fbpa_pkg::FREE_MAX) begin
          free_r <= free_r + fbpa_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // Result register, loaded at commit.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if ((op_mode_r == fbpa_pkg::MODE_ALLOC) && (free_r != '0)) begin
        out_res_r.granted     <= 1'b1;
        out_res_r.block_index <= head_r;
        out_res_r.byte_offset <= product[fbpa_pkg::OFFSET_W-1:0];
        out_res_r.free_count  <= free_dec;
      end else begin
        out_res_r.granted     <= 1'b0;
        out_res_r.block_index <= '0;
        out_res_r.byte_offset <= '0;
        if (op_mode_r == fbpa_pkg::MODE_FREE && free_r != fbpa_pkg::FREE_MAX) begin
          out_res_r.free_count <= free_r + fbpa_pkg::COUNT_W'(1);
        end else begin
          out_res_r.free_count <= free_r;
        end
      end
    end
  end

  assign out_res = out_res_r;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the fixed-size block pool allocator.
// Depends on fbpa_pkg and fixed_block_pool_allocator. It keeps its own copy of
// the pool state and checks every result strobe against that prediction.
module testbench;

  localparam int LINK_DEPTH = 256;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 125;
  localparam int POOL_SETTINGS [12] = '{256, 1, 2, 3, 7, 16, 64, 0, 255, 300, 511, 5};
  localparam int SIZE_SETTINGS [6] = '{64, 1, 65536, 131071, 0, 4095};

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  fbpa_pkg::in_req_t               in_req = '0;
  logic                            out_strobe;
  fbpa_pkg::out_res_t              out_res;
  logic                            cfg_we = 1'b0;
  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted pool state and register copies.
  logic [fbpa_pkg::LINK_W-1:0]  link_copy [LINK_DEPTH];
  bit                           link_written [LINK_DEPTH];
  logic [fbpa_pkg::IDX_W-1:0]   head_idx;
  bit                           head_ok;
  int unsigned                  free_cnt;
  int unsigned                  init_cnt;
  logic [fbpa_pkg::COUNT_W-1:0] num_blocks_reg;
  logic [fbpa_pkg::BSIZE_W-1:0] block_size_reg;

  // Blocks granted and not yet handed back by a well-formed free.
  int                 held_blocks [$];
  fbpa_pkg::out_res_t expected_results [$];

  int fail_count = 0;
  int request_count = 0;
  int grant_count = 0;
  int refuse_count = 0;
  int cfg_count = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  fixed_block_pool_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective block count: the register value capped at the pool limit.
  function automatic int unsigned pool_size();
    return (num_blocks_reg > fbpa_pkg::POOL_LIMIT) ? fbpa_pkg::POOL_LIMIT
                                                   : int'(num_blocks_reg);
  endfunction

  // A fresh pool: full, head at block zero, no links set yet.
  function automatic void recreate_pool();
    foreach (link_written[i]) begin
      link_written[i] = 1'b0;
      link_copy[i] = '0;
    end
    head_idx = '0;
    head_ok = 1'b1;
    free_cnt = pool_size();
    init_cnt = 0;
    held_blocks.delete();
  endfunction

  function automatic void reset_pool_model();
    num_blocks_reg = fbpa_pkg::NUM_BLOCKS_RST;
    block_size_reg = fbpa_pkg::BLOCK_SIZE_RST;
    recreate_pool();
  endfunction

  // True when an allocate now would follow the head into a link never set.
  function automatic bit alloc_hits_unwritten();
    bit lazy_fill;
    lazy_fill = (init_cnt < pool_size()) && (init_cnt == head_idx);
    return (free_cnt > 1) && !link_written[head_idx] && !lazy_fill;
  endfunction

  // Applies one request to the predicted pool and returns its result.
  function automatic fbpa_pkg::out_res_t predict_pool_step(fbpa_pkg::in_req_t req);
    fbpa_pkg::out_res_t res;
    int unsigned        n;
    n = pool_size();
    res = '0;
    if (req.mode == fbpa_pkg::MODE_ALLOC) begin
      // The lazily built list grows by one link per allocate.
      if (init_cnt < n) begin
        link_copy[init_cnt] = fbpa_pkg::LINK_W'(init_cnt + 1);
        link_written[init_cnt] = 1'b1;
        init_cnt++;
      end
      if (free_cnt > 0) begin
        res.granted = 1'b1;
        res.block_index = head_idx;
        res.byte_offset = fbpa_pkg::OFFSET_W'(32'(head_idx) * 32'(block_size_reg));
        held_blocks.push_back(int'(head_idx));
        grant_count++;
        free_cnt--;
        if (free_cnt != 0) begin
          head_idx = link_copy[head_idx][fbpa_pkg::IDX_W-1:0];
        end else begin
          head_ok = 1'b0;
        end
      end else begin
        refuse_count++;
      end
    end else begin
      // An empty list gets the block count as its end marker.
      link_copy[req.free_index] = head_ok ? fbpa_pkg::LINK_W'(head_idx)
                                          : fbpa_pkg::LINK_W'(n);
      link_written[req.free_index] = 1'b1;
      head_idx = req.free_index;
      head_ok = 1'b1;
      if (free_cnt < fbpa_pkg::FREE_MAX) free_cnt++;
    end
    res.free_count = fbpa_pkg::COUNT_W'(free_cnt);
    return res;
  endfunction

  function automatic fbpa_pkg::in_req_t pool_request(logic mode, int idx);
    fbpa_pkg::in_req_t req;
    req.mode = mode;
    req.free_index = fbpa_pkg::IDX_W'(idx);
    return req;
  endfunction

  // Mostly allocates and frees of held blocks, with some stray frees.
  function automatic fbpa_pkg::in_req_t next_pool_request(int free_pct);
    fbpa_pkg::in_req_t req;
    int                pick;
    req.mode = fbpa_pkg::MODE_ALLOC;
    req.free_index = fbpa_pkg::IDX_W'($urandom);
    if ($urandom_range(0, 99) < 10) begin
      req.mode = fbpa_pkg::MODE_FREE;
    end else if (held_blocks.size() != 0 && $urandom_range(0, 99) < free_pct) begin
      pick = $urandom_range(0, held_blocks.size() - 1);
      req.mode = fbpa_pkg::MODE_FREE;
      req.free_index = fbpa_pkg::IDX_W'(held_blocks[pick]);
      held_blocks.delete(pick);
    end
    // Freeing the head onto itself gives it a link, so the walk stays defined.
    if (req.mode == fbpa_pkg::MODE_ALLOC && alloc_hits_unwritten()) begin
      req.mode = fbpa_pkg::MODE_FREE;
      req.free_index = head_idx;
    end
    return req;
  endfunction

  // Sends one request after a random gap (none when gaps are off) and records its expected result.
  task automatic send_request(fbpa_pkg::in_req_t req);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_pool_step(req));
    request_count++;
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain_requests();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                                logic [fbpa_pkg::CFG_DATA_W-1:0] value);
    drain_requests();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fbpa_pkg::CFG_NUM_BLOCKS) begin
      num_blocks_reg = value[fbpa_pkg::COUNT_W-1:0];
      recreate_pool();
    end else begin
      block_size_reg = value[fbpa_pkg::BSIZE_W-1:0];
    end
    cfg_count++;
  endtask

  // Hand-picked cases: field extremes, offset wrap, zero block size,
  // exhausted and empty pools, and a block count above the limit.
  task automatic test_directed_cases();
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 255));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 255));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 0));
    // Largest block size: the offset of a high block wraps at 24 bits.
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, fbpa_pkg::CFG_DATA_W'(131071));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 200));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, fbpa_pkg::CFG_DATA_W'(0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    // One-block pool: run dry, get refused, refill through the empty list.
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, fbpa_pkg::CFG_DATA_W'(64));
    write_register(fbpa_pkg::CFG_NUM_BLOCKS, fbpa_pkg::CFG_DATA_W'(1));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 5));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 6));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    // A pool of no blocks refuses until something is freed into it.
    write_register(fbpa_pkg::CFG_NUM_BLOCKS, fbpa_pkg::CFG_DATA_W'(0));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    send_request(pool_request(fbpa_pkg::MODE_FREE, 9));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
    // A block count above the limit is capped.
    write_register(fbpa_pkg::CFG_NUM_BLOCKS, fbpa_pkg::CFG_DATA_W'(511));
    send_request(pool_request(fbpa_pkg::MODE_ALLOC, 0));
  endtask

  // Random traffic over a range of pool and block sizes.
  task automatic test_random_pools();
    int pool_cfg;
    int size_cfg;
    int free_pct;
    for (int phase = 0; phase < 12; phase++) begin
      pool_cfg = (phase == 11) ? $urandom_range(1, 256) : POOL_SETTINGS[phase];
      size_cfg = (phase % 3 == 2) ? $urandom_range(0, 131071) : SIZE_SETTINGS[phase % 6];
      write_register(fbpa_pkg::CFG_NUM_BLOCKS, fbpa_pkg::CFG_DATA_W'(pool_cfg));
      write_register(fbpa_pkg::CFG_BLOCK_SIZE, fbpa_pkg::CFG_DATA_W'(size_cfg));
      no_gaps = (phase % 4 == 3);
      free_pct = (phase % 2 == 0) ? 50 : 25;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Now and then let the pipeline run empty mid-stream.
        if ($urandom_range(0, 39) == 0) drain_requests();
        send_request(next_pool_request(free_pct));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Enough frees to drive the free count into saturation, then allocates.
  task automatic test_free_saturation();
    write_register(fbpa_pkg::CFG_NUM_BLOCKS, fbpa_pkg::CFG_DATA_W'(256));
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, fbpa_pkg::CFG_DATA_W'($urandom_range(1, 65536)));
    for (int i = 0; i < 280; i++) begin
      send_request(pool_request(fbpa_pkg::MODE_FREE, $urandom_range(0, 255)));
    end
    for (int i = 0; i < 20; i++) begin
      send_request(next_pool_request(0));
    end
  endtask

  // Compares each result strobe with the oldest prediction.
  always @(posedge clk) begin
    fbpa_pkg::out_res_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_res);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_res.granted !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, out_res.granted);
          fail_count++;
        end
        if (out_res.block_index !== want.block_index) begin
          $error("block_index: expected %0d, actual %0d", want.block_index,
                 out_res.block_index);
          fail_count++;
        end
        if (out_res.byte_offset !== want.byte_offset) begin
          $error("byte_offset: expected %0d, actual %0d", want.byte_offset,
                 out_res.byte_offset);
          fail_count++;
        end
        if (out_res.free_count !== want.free_count) begin
          $error("free_count: expected %0d, actual %0d", want.free_count,
                 out_res.free_count);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_pool_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_pools();
    test_free_saturation();
    drain_requests();
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Ran %0d requests (%0d grants, %0d refused allocates) across %0d register writes,",
             request_count, grant_count, refuse_count, cfg_count);
    $display("covering small, empty, capped and saturated pools and wrapping offsets.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
